/* rtl/plpd_pkg.sv */
package plpd_pkg;

   localparam int NUMBER_DIGITS = 10;
   localparam int MAX_BREAKS    = 20;

   localparam int TIME_W      = 16;
   localparam int BREAK_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int NUMBER_W    = 40;
   localparam int CSR_INDEX_W = 8;
   localparam int DIGIT_CNT_W = $clog2(NUMBER_DIGITS + 1);
   localparam int DIGIT_IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

   localparam logic [DIGIT_CNT_W-1:0] FULL_COUNT     = DIGIT_CNT_W'(NUMBER_DIGITS);
   localparam logic [BREAK_W-1:0]     MAX_BREAK_CNT  = BREAK_W'(MAX_BREAKS);
   localparam logic [BREAK_W-1:0]     ZERO_BREAKS    = BREAK_W'(10);
   localparam logic [DIGIT_W-1:0]     LAST_DIGIT     = DIGIT_W'(9);
   localparam logic [TIME_W-1:0]      TIME_SAT       = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_HANGUP_DELAY = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE       = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP          = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE     = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_DTMF_GUARD   = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT      = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_PERIOD  = CSR_INDEX_W'(6);
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_ON      = CSR_INDEX_W'(7);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RING = 2'd1,
      MODE_OFF  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SRC_NONE  = 2'd0,
      SRC_TONE  = 2'd1,
      SRC_PULSE = 2'd2
   } src_type;

   typedef struct packed {
      logic [TIME_W-1:0] hangup_delay_ms;
      logic [TIME_W-1:0] settle_ms;
      logic [TIME_W-1:0] interdigit_gap_ms;
      logic [TIME_W-1:0] edge_debounce_ms;
      logic [TIME_W-1:0] dtmf_guard_ms;
      logic [TIME_W-1:0] digit_timeout_ms;
      logic [TIME_W-1:0] ring_period_ms;
      logic [TIME_W-1:0] ring_on_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      hangup_delay_ms:   16'd800,
      settle_ms:         16'd40,
      interdigit_gap_ms: 16'd420,
      edge_debounce_ms:  16'd18,
      dtmf_guard_ms:     16'd900,
      digit_timeout_ms:  16'd10000,
      ring_period_ms:    16'd5000,
      ring_on_ms:        16'd1000
   };

   typedef struct packed {
      logic               handset_up;
      logic               ring_write;
      logic               ring_value;
      logic               dtmf_valid;
      logic [DIGIT_W-1:0] dtmf_digit;
   } req_type;

   typedef struct packed {
      logic [1:0]          line_state;
      logic                ring_drive;
      logic                dial_tone;
      logic                answer_request;
      logic                digit_accepted;
      logic [DIGIT_W-1:0]  digit_value;
      logic                digit_source;
      logic [3:0]          digits_held;
      logic                dial_request;
      logic [NUMBER_W-1:0] dialed_number;
   } rsp_type;

   typedef struct packed {
      mode_type               mode;
      logic                   ring_req;
      logic                   phase;
      logic [TIME_W-1:0]      cadence;
      logic                   hook_seen;
      logic                   prev_hook;
      logic                   collecting;
      logic [BREAK_W-1:0]     breaks;
      logic [TIME_W-1:0]      since_hook_edge;
      logic [TIME_W-1:0]      since_break;
      logic [TIME_W-1:0]      since_db_edge;
      logic                   edge_seen;
      logic [TIME_W-1:0]      since_offhook;
      logic [TIME_W-1:0]      since_digit;
      src_type                src;
      logic                   begun;
      logic                   muted;
      logic                   tone;
      logic [DIGIT_CNT_W-1:0] count;
   } state_type;

   localparam state_type STATE_RESET = '{mode: MODE_IDLE, src: SRC_NONE, default: '0};

   typedef logic [NUMBER_DIGITS-1:0][DIGIT_W-1:0] store_type;

   typedef struct packed {
      state_type           st;
      store_type           store;
      logic                acc;
      logic [DIGIT_W-1:0]  acc_value;
      logic                acc_src;
      logic                dial;
      logic [NUMBER_W-1:0] number;
   } work_type;

endpackage

/* rtl/phone_line_pulse_dial_controller.sv */
// Phone line controller with rotary pulse and DTMF digit decoding, one request beat per millisecond tick.
// Every accepted beat is processed combinationally and its response beat appears in the output
// register on the next cycle; beats may follow each other in every cycle. The only limit on
// throughput is the single output register: while a response is stalled, the request side
// is stalled too. Configuration writes are always ready and take effect on the next tick.
module phone_line_pulse_dial_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  plpd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output plpd_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [plpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [plpd_pkg::TIME_W-1:0]      csr_data
);
   import plpd_pkg::*;

   cfg_type   cfg;
   state_type st_ff;
   state_type st_in;
   store_type store_ff;
   store_type store_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_accept;

   function automatic logic [TIME_W-1:0] sat_inc(logic [TIME_W-1:0] v);
      return (v == TIME_SAT) ? v : v + TIME_W'(1);
   endfunction

   function automatic state_type clear_session(state_type s);
      state_type r;
      r                 = s;
      r.hook_seen       = 1'b0;
      r.collecting      = 1'b0;
      r.breaks          = '0;
      r.since_hook_edge = '0;
      r.since_offhook   = '0;
      r.edge_seen       = 1'b0;
      r.since_db_edge   = '0;
      r.src             = SRC_NONE;
      r.begun           = 1'b0;
      r.count           = '0;
      return r;
   endfunction

   function automatic work_type add_digit(work_type w, logic [DIGIT_W-1:0] d,
                                          logic by_pulse, logic tone_block);
      work_type            r;
      src_type             src;
      logic                ok;
      logic [NUMBER_W-1:0] n;
      r   = w;
      src = by_pulse ? SRC_PULSE : SRC_TONE;
      ok  = 1'b1;
      n   = '0;
      if (d > LAST_DIGIT) ok = 1'b0;
      if (!by_pulse && tone_block) ok = 1'b0;
      if (ok) begin
         if (r.st.src == SRC_NONE) begin
            r.st.src = src;
         end else if (r.st.src != src) begin
            if (by_pulse && r.st.src == SRC_TONE && r.st.count <= DIGIT_CNT_W'(1)) begin
               r.st.count = '0;
               r.st.src   = src;
            end else begin
               ok = 1'b0;
            end
         end
      end
      if (ok) begin
         if (r.st.count == '0) r.st.tone = 1'b0;
         r.st.begun = 1'b1;
         if (r.st.count >= FULL_COUNT) r.st.count = '0;
         r.store[r.st.count[DIGIT_IDX_W-1:0]] = d;
         r.st.count       = r.st.count + DIGIT_CNT_W'(1);
         r.st.since_digit = '0;
         r.acc            = 1'b1;
         r.acc_value      = d;
         r.acc_src        = by_pulse;
         if (r.st.count == FULL_COUNT) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
               n = {n[NUMBER_W-DIGIT_W-1:0], r.store[i]};
            end
            r.st.tone  = 1'b0;
            r.dial     = 1'b1;
            r.number   = n;
            r.st.count = '0;
         end
      end
      return r;
   endfunction

   plpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      work_type           w;
      mode_type           prev_mode;
      logic [BREAK_W-1:0] done_breaks;
      logic [TIME_W:0]    cad_next;
      logic               tone_block;
      logic               answer;

      w           = '{st: st_ff, store: store_ff, default: '0};
      prev_mode   = st_ff.mode;
      done_breaks = '0;
      cad_next    = '0;
      tone_block  = 1'b0;
      answer      = 1'b0;

      if (req_data.ring_write) w.st.ring_req = req_data.ring_value;

      w.st.since_hook_edge = sat_inc(w.st.since_hook_edge);
      w.st.since_break     = sat_inc(w.st.since_break);
      w.st.since_db_edge   = sat_inc(w.st.since_db_edge);
      w.st.since_offhook   = sat_inc(w.st.since_offhook);
      w.st.since_digit     = sat_inc(w.st.since_digit);

      unique case (w.st.mode)
         MODE_IDLE: begin
            if (w.st.ring_req && !req_data.handset_up) begin
               w.st.cadence = '0;
               w.st.phase   = 1'b1;
               w.st.mode    = MODE_RING;
            end else if (req_data.handset_up) begin
               w.st.mode = MODE_OFF;
            end
         end
         MODE_RING: begin
            if (req_data.handset_up) begin
               w.st.ring_req = 1'b0;
               w.st.phase    = 1'b0;
               answer        = 1'b1;
               w.st.muted    = 1'b1;
               w.st.mode     = MODE_OFF;
            end else if (!w.st.ring_req) begin
               w.st.phase = 1'b0;
               w.st.mode  = MODE_IDLE;
            end else begin
               cad_next = {1'b0, w.st.cadence} + (TIME_W + 1)'(1);
               if (cfg.ring_period_ms != '0 && cad_next >= {1'b0, cfg.ring_period_ms}) begin
                  cad_next = '0;
               end
               w.st.cadence = cad_next[TIME_W-1:0];
               w.st.phase   = w.st.cadence < cfg.ring_on_ms;
            end
         end
         default: begin
            if (w.st.since_offhook >= cfg.settle_ms) begin
               if (!w.st.hook_seen) begin
                  w.st.hook_seen       = 1'b1;
                  w.st.prev_hook       = req_data.handset_up;
                  w.st.since_hook_edge = '0;
               end else if (req_data.handset_up != w.st.prev_hook &&
                            !(w.st.edge_seen && w.st.since_db_edge < cfg.edge_debounce_ms)) begin
                  w.st.edge_seen     = 1'b1;
                  w.st.since_db_edge = '0;
                  w.st.tone          = 1'b0;
                  w.st.begun         = 1'b1;
                  if (w.st.prev_hook && !req_data.handset_up) begin
                     if (!w.st.collecting) begin
                        w.st.collecting = 1'b1;
                        w.st.breaks     = '0;
                     end
                  end else if (w.st.collecting && w.st.breaks < MAX_BREAK_CNT) begin
                     w.st.breaks      = w.st.breaks + BREAK_W'(1);
                     w.st.since_break = '0;
                  end
                  w.st.prev_hook       = req_data.handset_up;
                  w.st.since_hook_edge = '0;
               end
            end
            if (!req_data.handset_up) begin
               w.st.tone = 1'b0;
               if (w.st.count != '0 || w.st.src != SRC_NONE || w.st.collecting ||
                   w.st.breaks != '0) begin
                  w.st.count      = '0;
                  w.st.src        = SRC_NONE;
                  w.st.begun      = 1'b0;
                  w.st.collecting = 1'b0;
                  w.st.breaks     = '0;
               end
               if (w.st.since_hook_edge >= cfg.hangup_delay_ms) begin
                  w.st.ring_req = 1'b0;
                  w.st.mode     = MODE_IDLE;
               end
            end else begin
               if (w.st.collecting && w.st.breaks != '0 &&
                   w.st.since_break >= cfg.interdigit_gap_ms) begin
                  done_breaks     = w.st.breaks;
                  w.st.collecting = 1'b0;
                  w.st.breaks     = '0;
                  if (done_breaks == ZERO_BREAKS) begin
                     w = add_digit(w, '0, 1'b1, 1'b0);
                  end else if (done_breaks <= BREAK_W'(LAST_DIGIT)) begin
                     w = add_digit(w, done_breaks[DIGIT_W-1:0], 1'b1, 1'b0);
                  end
               end
               tone_block = w.st.collecting || w.st.breaks != '0 ||
                            (w.st.edge_seen && w.st.since_db_edge < cfg.dtmf_guard_ms);
               if (req_data.dtmf_valid) begin
                  w = add_digit(w, req_data.dtmf_digit, 1'b0, tone_block);
               end
               if (w.st.muted) w.st.tone = 1'b0;
               if (!w.st.muted && !w.st.begun && w.st.count == '0 && !w.st.tone &&
                   !(w.st.collecting || w.st.breaks != '0 ||
                     (w.st.edge_seen && w.st.since_db_edge < cfg.interdigit_gap_ms))) begin
                  w.st.tone = 1'b1;
               end
               if (w.st.count != '0 && w.st.since_digit >= cfg.digit_timeout_ms) begin
                  w.st.count = '0;
               end
            end
         end
      endcase

      if (prev_mode != w.st.mode) begin
         if (w.st.mode == MODE_OFF) begin
            w.st = clear_session(w.st);
            if (!w.st.muted) w.st.tone = 1'b1;
         end
         if (prev_mode == MODE_OFF) begin
            w.st       = clear_session(w.st);
            w.st.tone  = 1'b0;
            w.st.muted = 1'b0;
         end
      end

      st_in    = w.st;
      store_in = w.store;

      rsp_data_in.line_state     = w.st.mode;
      rsp_data_in.ring_drive     = w.st.phase;
      rsp_data_in.dial_tone      = w.st.tone;
      rsp_data_in.answer_request = answer;
      rsp_data_in.digit_accepted = w.acc;
      rsp_data_in.digit_value    = w.acc_value;
      rsp_data_in.digit_source   = w.acc_src;
      rsp_data_in.digits_held    = 4'(w.st.count);
      rsp_data_in.dial_request   = w.dial;
      rsp_data_in.dialed_number  = w.number;
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         store_ff    <= store_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/plpd_csr.sv */
module plpd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [plpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [plpd_pkg::TIME_W-1:0]      csr_data,
   output plpd_pkg::cfg_type                cfg
);
   import plpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HANGUP_DELAY: cfg_in.hangup_delay_ms   = csr_data;
            CSR_SETTLE:       cfg_in.settle_ms         = csr_data;
            CSR_GAP:          cfg_in.interdigit_gap_ms = csr_data;
            CSR_DEBOUNCE:     cfg_in.edge_debounce_ms  = csr_data;
            CSR_DTMF_GUARD:   cfg_in.dtmf_guard_ms     = csr_data;
            CSR_TIMEOUT:      cfg_in.digit_timeout_ms  = csr_data;
            CSR_RING_PERIOD:  cfg_in.ring_period_ms    = csr_data;
            CSR_RING_ON:      cfg_in.ring_on_ms        = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* verif/dial_line_checker.sv */
module dial_line_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  plpd_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  plpd_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [plpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [plpd_pkg::TIME_W-1:0]      csr_data,
   output int                               failures,
   output int                               pending
);

   import plpd_pkg::*;

   cfg_type                regs;
   mode_type               mode;
   src_type                src;
   logic                   ring_req, ring_phase, hook_seen, prev_hook, collecting;
   logic                   edge_seen, begun, muted, tone_on;
   logic [BREAK_W-1:0]     breaks;
   logic [TIME_W-1:0]      cadence, since_hook_edge, since_break, since_edge;
   logic [TIME_W-1:0]      since_offhook, since_digit;
   logic [DIGIT_W-1:0]     digits [NUMBER_DIGITS];
   logic [DIGIT_CNT_W-1:0] held;
   rsp_type                report;
   rsp_type                want;
   rsp_type                awaited_reports [$];
   int                     errs = 0;

   function automatic logic [TIME_W-1:0] bump(input logic [TIME_W-1:0] v);
      return (v == TIME_SAT) ? v : v + TIME_W'(1);
   endfunction

   function automatic void drop_session();
      hook_seen = 1'b0;
      collecting = 1'b0;
      breaks = '0;
      since_hook_edge = '0;
      since_offhook = '0;
      edge_seen = 1'b0;
      since_edge = '0;
      src = SRC_NONE;
      begun = 1'b0;
      held = '0;
   endfunction

   function automatic void take_digit(input logic [DIGIT_W-1:0] d, input logic pulse);
      src_type             from;
      logic [NUMBER_W-1:0] number;
      from = pulse ? SRC_PULSE : SRC_TONE;
      if (d > LAST_DIGIT) return;
      if (!pulse && (collecting || breaks != '0 ||
                     (edge_seen && since_edge < regs.dtmf_guard_ms))) return;
      if (src == SRC_NONE) begin
         src = from;
      end else if (src != from) begin
         if (pulse && src == SRC_TONE && held <= DIGIT_CNT_W'(1)) begin
            held = '0;
            src = from;
         end else begin
            return;
         end
      end
      if (held == '0) tone_on = 1'b0;
      begun = 1'b1;
      if (held >= FULL_COUNT) held = '0;
      digits[held] = d;
      held = held + DIGIT_CNT_W'(1);
      since_digit = '0;
      report.digit_accepted = 1'b1;
      report.digit_value = d;
      report.digit_source = pulse;
      if (held == FULL_COUNT) begin
         number = '0;
         for (int i = 0; i < NUMBER_DIGITS; i++)
            number = {number[NUMBER_W-DIGIT_W-1:0], digits[i]};
         tone_on = 1'b0;
         report.dial_request = 1'b1;
         report.dialed_number = number;
         held = '0;
      end
   endfunction

   function automatic void track_hook(input logic hook);
      if (!hook_seen) begin
         hook_seen = 1'b1;
         prev_hook = hook;
         since_hook_edge = '0;
         return;
      end
      if (hook == prev_hook) return;
      if (edge_seen && since_edge < regs.edge_debounce_ms) return;
      edge_seen = 1'b1;
      since_edge = '0;
      tone_on = 1'b0;
      begun = 1'b1;
      if (prev_hook && !hook) begin
         if (!collecting) begin
            collecting = 1'b1;
            breaks = '0;
         end
      end else if (collecting && breaks < MAX_BREAK_CNT) begin
         breaks = breaks + BREAK_W'(1);
         since_break = '0;
      end
      prev_hook = hook;
      since_hook_edge = '0;
   endfunction

   function automatic rsp_type advance_line(input req_type r);
      mode_type           was;
      logic               answer;
      logic [TIME_W:0]    next_count;
      logic [BREAK_W-1:0] count_now;
      was = mode;
      answer = 1'b0;
      report = '0;
      if (r.ring_write) ring_req = r.ring_value;
      since_hook_edge = bump(since_hook_edge);
      since_break = bump(since_break);
      since_edge = bump(since_edge);
      since_offhook = bump(since_offhook);
      since_digit = bump(since_digit);
      case (mode)
         MODE_IDLE: begin
            if (ring_req && !r.handset_up) begin
               cadence = '0;
               ring_phase = 1'b1;
               mode = MODE_RING;
            end else if (r.handset_up) begin
               mode = MODE_OFF;
            end
         end
         MODE_RING: begin
            if (r.handset_up) begin
               ring_req = 1'b0;
               ring_phase = 1'b0;
               answer = 1'b1;
               muted = 1'b1;
               mode = MODE_OFF;
            end else if (!ring_req) begin
               ring_phase = 1'b0;
               mode = MODE_IDLE;
            end else begin
               next_count = {1'b0, cadence} + (TIME_W + 1)'(1);
               if (regs.ring_period_ms != '0 && next_count >= {1'b0, regs.ring_period_ms})
                  next_count = '0;
               cadence = next_count[TIME_W-1:0];
               ring_phase = (cadence < regs.ring_on_ms);
            end
         end
         default: begin
            if (since_offhook >= regs.settle_ms) track_hook(r.handset_up);
            if (!r.handset_up) begin
               tone_on = 1'b0;
               if (held != '0 || src != SRC_NONE || collecting || breaks != '0) begin
                  held = '0;
                  src = SRC_NONE;
                  begun = 1'b0;
                  collecting = 1'b0;
                  breaks = '0;
               end
               if (since_hook_edge >= regs.hangup_delay_ms) begin
                  ring_req = 1'b0;
                  mode = MODE_IDLE;
               end
            end else begin
               if (collecting && breaks != '0 && since_break >= regs.interdigit_gap_ms) begin
                  count_now = breaks;
                  collecting = 1'b0;
                  breaks = '0;
                  if (count_now == ZERO_BREAKS) take_digit('0, 1'b1);
                  else if (count_now <= BREAK_W'(LAST_DIGIT))
                     take_digit(count_now[DIGIT_W-1:0], 1'b1);
               end
               if (r.dtmf_valid) take_digit(r.dtmf_digit, 1'b0);
               if (muted) tone_on = 1'b0;
               if (!muted && !begun && held == '0 && !tone_on &&
                   !(collecting || breaks != '0 ||
                     (edge_seen && since_edge < regs.interdigit_gap_ms)))
                  tone_on = 1'b1;
               if (held != '0 && since_digit >= regs.digit_timeout_ms) held = '0;
            end
         end
      endcase
      if (was != mode) begin
         if (mode == MODE_OFF) begin
            drop_session();
            if (!muted) tone_on = 1'b1;
         end
         if (was == MODE_OFF) begin
            drop_session();
            tone_on = 1'b0;
            muted = 1'b0;
         end
      end
      report.line_state = mode;
      report.ring_drive = ring_phase;
      report.dial_tone = tone_on;
      report.answer_request = answer;
      report.digits_held = held;
      return report;
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", field, want_v, got_v);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         regs = CFG_RESET;
         mode = MODE_IDLE;
         ring_req = 1'b0;
         ring_phase = 1'b0;
         cadence = '0;
         prev_hook = 1'b0;
         since_break = '0;
         since_digit = '0;
         drop_session();
         muted = 1'b0;
         tone_on = 1'b0;
         for (int i = 0; i < NUMBER_DIGITS; i++) digits[i] = '0;
         awaited_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HANGUP_DELAY: regs.hangup_delay_ms = csr_data;
               CSR_SETTLE:       regs.settle_ms = csr_data;
               CSR_GAP:          regs.interdigit_gap_ms = csr_data;
               CSR_DEBOUNCE:     regs.edge_debounce_ms = csr_data;
               CSR_DTMF_GUARD:   regs.dtmf_guard_ms = csr_data;
               CSR_TIMEOUT:      regs.digit_timeout_ms = csr_data;
               CSR_RING_PERIOD:  regs.ring_period_ms = csr_data;
               CSR_RING_ON:      regs.ring_on_ms = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $error("line report beat with no tick outstanding");
               errs++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("line_state", want.line_state, rsp_data.line_state);
               check_field("ring_drive", want.ring_drive, rsp_data.ring_drive);
               check_field("dial_tone", want.dial_tone, rsp_data.dial_tone);
               check_field("answer_request", want.answer_request, rsp_data.answer_request);
               check_field("digit_accepted", want.digit_accepted, rsp_data.digit_accepted);
               check_field("digit_value", want.digit_value, rsp_data.digit_value);
               check_field("digit_source", want.digit_source, rsp_data.digit_source);
               check_field("digits_held", want.digits_held, rsp_data.digits_held);
               check_field("dial_request", want.dial_request, rsp_data.dial_request);
               check_field("dialed_number", want.dialed_number, rsp_data.dialed_number);
            end
         end
         if (req_valid && !req_stall) awaited_reports.push_back(advance_line(req_data));
      end
      failures <= errs;
      pending <= awaited_reports.size();
   end

endmodule

/* verif/tb_top.sv */
module tb_top;

   import plpd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_TICKS = 150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]      csr_data = '0;

   int      failures;
   int      pending;
   int      burst_left = 0;
   int      ticks_sent = 0;
   int      quiet_cycles = 0;
   int      stall_kind = 0;
   int      stall_span = 0;
   cfg_type line_cfg = CFG_RESET;

   phone_line_pulse_dial_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dial_line_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 300);
      end
      stall_span--;
      case (stall_kind)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ((stall_span % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type tick(input logic hook, input logic rw, input logic rv,
                                    input logic dv, input logic [DIGIT_W-1:0] dd);
      req_type t;
      t.handset_up = hook;
      t.ring_write = rw;
      t.ring_value = rv;
      t.dtmf_valid = dv;
      t.dtmf_digit = dd;
      return t;
   endfunction

   function automatic int span(input logic [TIME_W-1:0] v);
      return (v <= 40) ? int'(v) + int'($urandom_range(0, 2)) : int'($urandom_range(1, 12));
   endfunction

   function automatic logic [TIME_W-1:0] pick_ms(input logic [TIME_W-1:0] lo);
      case ($urandom_range(0, 9))
         0: return lo;
         1: return TIME_SAT;
         default: return TIME_W'($urandom_range(lo, 12));
      endcase
   endfunction

   task automatic send(input req_type item);
      if (burst_left == 0)
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
      burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic hold_line(input logic hook, input int n);
      repeat (n) send(tick(hook, 1'b0, 1'b0, 1'b0, '0));
   endtask

   task automatic quiesce();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      logic [CSR_INDEX_W-1:0] idx [8];
      logic [TIME_W-1:0]      val [8];
      idx = '{CSR_HANGUP_DELAY, CSR_SETTLE, CSR_GAP, CSR_DEBOUNCE,
              CSR_DTMF_GUARD, CSR_TIMEOUT, CSR_RING_PERIOD, CSR_RING_ON};
      val = '{c.hangup_delay_ms, c.settle_ms, c.interdigit_gap_ms, c.edge_debounce_ms,
              c.dtmf_guard_ms, c.digit_timeout_ms, c.ring_period_ms, c.ring_on_ms};
      quiesce();
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      line_cfg = c;
   endtask

   task automatic hang_up();
      hold_line(1'b0, span(line_cfg.hangup_delay_ms) + 1);
   endtask

   task automatic tone_call();
      int          digits_left;
      logic [3:0]  d;
      hold_line(1'b1, span(line_cfg.settle_ms) + 1);
      digits_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(10, 13);
      repeat (digits_left) begin
         d = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
         send(tick(1'b1, 1'b0, 1'b0, 1'b1, d));
         if ($urandom_range(0, 9) == 0) hold_line(1'b1, span(line_cfg.digit_timeout_ms));
         else hold_line(1'b1, $urandom_range(0, 2));
      end
      hang_up();
   endtask

   task automatic rotary_call();
      int breaks;
      hold_line(1'b1, span(line_cfg.settle_ms) + 1);
      repeat ($urandom_range(1, 2)) begin
         breaks = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 23) : $urandom_range(1, 10);
         repeat (breaks) begin
            hold_line(1'b0, span(line_cfg.edge_debounce_ms) + 1);
            hold_line(1'b1, span(line_cfg.edge_debounce_ms) + 1);
         end
         hold_line(1'b1, span(line_cfg.interdigit_gap_ms) + 1);
      end
      send(tick(1'b1, 1'b0, 1'b0, 1'b1, 4'($urandom_range(0, 9))));
      hold_line(1'b1, span(line_cfg.dtmf_guard_ms));
      send(tick(1'b1, 1'b0, 1'b0, 1'b1, 4'($urandom_range(0, 9))));
      hang_up();
   endtask

   task automatic incoming_call();
      send(tick(1'b0, 1'b1, 1'b1, 1'b0, '0));
      hold_line(1'b0, $urandom_range(1, 25));
      case ($urandom_range(0, 2))
         0: begin
            send(tick(1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 9))));
            repeat ($urandom_range(1, 12))
               send(tick(1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                         4'($urandom_range(0, 9))));
            hang_up();
         end
         1: send(tick(1'b0, 1'b1, 1'b0, 1'b0, '0));
         default: begin
            send(tick(1'b1, 1'b0, 1'b0, 1'b0, '0));
            hang_up();
         end
      endcase
   endtask

   task automatic line_noise();
      repeat ($urandom_range(5, 30))
         send(tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))));
   endtask

   task automatic run_calls(input int n);
      int stop_at;
      stop_at = ticks_sent + n;
      while (ticks_sent < stop_at) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: tone_call();
            8, 9, 10, 11:           rotary_call();
            12, 13, 14, 15, 16:     incoming_call();
            default:                line_noise();
         endcase
      end
   endtask

   initial begin
      cfg_type c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(tick(1'b0, 1'b1, 1'b1, 1'b0, '0));
      hold_line(1'b0, 4);
      c = '{hangup_delay_ms: 16'd3, settle_ms: 16'd1, interdigit_gap_ms: 16'd2,
            edge_debounce_ms: 16'd1, dtmf_guard_ms: 16'd4, digit_timeout_ms: 16'd6,
            ring_period_ms: 16'd2, ring_on_ms: 16'd0};
      program_regs(c);
      send(tick(1'b0, 1'b0, 1'b0, 1'b0, '0));
      send(tick(1'b1, 1'b0, 1'b0, 1'b1, 4'd9));
      send(tick(1'b1, 1'b0, 1'b0, 1'b1, 4'd0));
      send(tick(1'b1, 1'b0, 1'b0, 1'b1, 4'd15));
      hold_line(1'b0, 5);
      send(tick(1'b0, 1'b1, 1'b1, 1'b1, 4'd15));
      send(tick(1'b0, 1'b1, 1'b0, 1'b0, '0));
      send(tick(1'b1, 1'b0, 1'b0, 1'b0, '0));
      hold_line(1'b1, 2);
      hold_line(1'b0, 1);
      hold_line(1'b1, 3);
      send(tick(1'b1, 1'b0, 1'b0, 1'b1, 4'd5));
      hold_line(1'b0, 5);

      c = '{hangup_delay_ms: 16'd12, settle_ms: 16'd3, interdigit_gap_ms: 16'd8,
            edge_debounce_ms: 16'd2, dtmf_guard_ms: 16'd10, digit_timeout_ms: 16'd30,
            ring_period_ms: 16'd9, ring_on_ms: 16'd4};
      program_regs(c);
      run_calls(PHASE_TICKS);

      program_regs('0);
      run_calls(PHASE_TICKS);

      program_regs('1);
      run_calls(PHASE_TICKS);

      repeat (4) begin
         c.hangup_delay_ms = pick_ms(16'd0);
         c.settle_ms = pick_ms(16'd0);
         c.interdigit_gap_ms = pick_ms(16'd0);
         c.edge_debounce_ms = pick_ms(16'd0);
         c.dtmf_guard_ms = pick_ms(16'd0);
         c.digit_timeout_ms = pick_ms(16'd0);
         c.ring_period_ms = pick_ms(16'd1);
         c.ring_on_ms = pick_ms(16'd0);
         program_regs(c);
         run_calls(PHASE_TICKS);
      end

      program_regs(CFG_RESET);
      run_calls(40);

      quiesce();
      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
rtl/plpd_pkg.sv
rtl/plpd_csr.sv
rtl/phone_line_pulse_dial_controller.sv
verif/dial_line_checker.sv
verif/tb_top.sv
